### sv/dtf_pkg.sv
package dtf_pkg;

  // Operation codes carried on the func port.
  localparam logic [2:0] FUNC_DRAW         = 3'd0;
  localparam logic [2:0] FUNC_CLEAR        = 3'd1;
  localparam logic [2:0] FUNC_RENDER_COUNT = 3'd2;
  localparam logic [2:0] FUNC_RENDER_ALL   = 3'd3;
  localparam logic [2:0] FUNC_TICK         = 3'd4;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Fixed-point shift used for division by the tile size.
  localparam int DIV_SHIFT = 18;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TILE_START,
    ST_PIX_RD,
    ST_PIX_OUT
  } dtf_state_t;

  // Status returned by the draw address unit.
  typedef struct packed {
    logic done;
    logic on_screen;
  } draw_stat_t;

endpackage

### sv/dtf_ram.sv
module dtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 76800,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/dtf_draw_addr.sv
module dtf_draw_addr
  import dtf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int TILE_SIZE     = 8,
  parameter int GRID_COLUMNS  = 40,
  parameter int GRID_ROWS     = 30,
  localparam int TP          = TILE_SIZE * TILE_SIZE,
  localparam int NUM_TILES   = GRID_COLUMNS * GRID_ROWS,
  localparam int STORE_DEPTH = NUM_TILES * TP,
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
  localparam int TW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1,
  localparam int CW = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1,
  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [8:0]    x,
  input  logic [8:0]    y,
  output draw_stat_t    stat,
  output logic [TW-1:0] tile,
  output logic [CW-1:0] col,
  output logic [RW-1:0] row,
  output logic [AW-1:0] addr
);

  localparam int TB    = $clog2(TILE_SIZE);
  localparam int RECIP = ((1 << DIV_SHIFT) + TILE_SIZE - 1) / TILE_SIZE;

  logic          v1, v2, v3;
  logic [8:0]    x1, y1, qx1, qy1;
  logic          in1, on2, on3;
  logic [TB-1:0] rx2, ry2;
  logic [TW-1:0] t2, t3;
  logic [CW-1:0] col2, col3;
  logic [RW-1:0] row2, row3;
  logic [AW-1:0] addr3;

  logic [26:0]   prod_x, prod_y;
  logic [8:0]    qx, qy;
  logic [TB-1:0] rx, ry;
  logic [17:0]   t_wide;
  logic          on_grid;
  logic [AW-1:0] addr_c;

  // Stage one: tile column and row by reciprocal multiplication.
  assign prod_x = 27'(x) * 27'(RECIP);
  assign prod_y = 27'(y) * 27'(RECIP);
  assign qx     = 9'(prod_x >> DIV_SHIFT);
  assign qy     = 9'(prod_y >> DIV_SHIFT);

  // Stage two: offsets within the tile and the tile number.
  assign rx      = TB'(x1 - 9'(32'(qx1) * TILE_SIZE));
  assign ry      = TB'(y1 - 9'(32'(qy1) * TILE_SIZE));
  assign t_wide  = 18'(qx1) + 18'(qy1) * 18'(GRID_COLUMNS);
  assign on_grid = (32'(qx1) < GRID_COLUMNS) && (32'(qy1) < GRID_ROWS);

  // Stage three: linear address within the tiled store.
  assign addr_c = AW'(32'(t2) * TP + 32'(ry2) * TILE_SIZE + 32'(rx2));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= go;
      v2 <= v1;
      v3 <= v2;
    end
    x1    <= x;
    y1    <= y;
    qx1   <= qx;
    qy1   <= qy;
    in1   <= (32'(x) < SCREEN_WIDTH) && (32'(y) < SCREEN_HEIGHT);
    rx2   <= rx;
    ry2   <= ry;
    t2    <= TW'(t_wide);
    col2  <= CW'(qx1);
    row2  <= RW'(qy1);
    on2   <= in1 && on_grid;
    addr3 <= addr_c;
    t3    <= t2;
    col3  <= col2;
    row3  <= row2;
    on3   <= on2;
  end

  assign stat.done      = v3;
  assign stat.on_screen = on3;
  assign tile           = t3;
  assign col            = col3;
  assign row            = row3;
  assign addr           = addr3;

endmodule

### sv/dirty_tile_framebuffer_flush.sv
// Tiled shadow framebuffer with per-tile dirty marks and a deferred flush.
// Commands enter on start while busy is low; func selects draw, clear,
// render count, render all or tick. Results leave on the result ports for
// one cycle, marked by result_strobe; the receiver cannot stall them.
// A draw keeps busy high after its beat while it passes the address
// pipeline of three registered steps, and gives no result. Render requests
// leave busy low. A tick inside a tile keeps busy high through one pixel
// memory read (ST_PIX_RD, ST_PIX_OUT), and its pixel appears in the same
// cycle that busy falls. A tick that opens a tile first scans the dirty
// bitmap, one bitmap read and its check for each tile examined, then goes
// through ST_TILE_START, ST_PIX_RD and ST_PIX_OUT. A clear shows its
// clear-screen result on the cycle after its beat, then sweeps every pixel
// (and the dirty bitmap alongside) at one entry a cycle over the
// GRID_COLUMNS x GRID_ROWS x TILE_SIZE x TILE_SIZE entries of the tiled
// store, 76800 at the default size, with busy high throughout. After reset
// the same sweep runs with black, and no command is accepted until it ends.
module dirty_tile_framebuffer_flush
  import dtf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int TILE_SIZE     = 8,
  parameter int GRID_COLUMNS  = 40,
  parameter int GRID_ROWS     = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [8:0]  pixel_x,
  input  logic [8:0]  pixel_y,
  input  logic [15:0] color,
  input  logic [10:0] tile_count,
  output logic        result_strobe,
  output logic        kind,
  output logic [8:0]  window_x,
  output logic [7:0]  window_y,
  output logic [15:0] pixel_color,
  output logic        first_of_tile,
  output logic        last_of_tile
);

  localparam int TP          = TILE_SIZE * TILE_SIZE;
  localparam int NUM_TILES   = GRID_COLUMNS * GRID_ROWS;
  localparam int STORE_DEPTH = NUM_TILES * TP;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int TW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  localparam int CW = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int PW = $clog2(TP);

  dtf_state_t state, state_next;

  logic          accept;
  logic [AW-1:0] sweep_cnt;
  logic [15:0]   fill_color;
  logic [15:0]   draw_color;
  logic [TW-1:0] range_first, range_last;
  logic [CW-1:0] range_first_col;
  logic [RW-1:0] range_first_row;
  logic          range_valid;
  logic [10:0]   budget;
  logic          unlimited;
  logic [PW-1:0] pos;
  logic [TW-1:0] scan_t;
  logic [CW-1:0] scan_col, scan_col_inc;
  logic [RW-1:0] scan_row, scan_row_inc;
  logic [AW-1:0] stream_base;
  logic [8:0]    stream_wx;
  logic [7:0]    stream_wy;
  logic          sweep_dirty;
  logic          armed;

  // Memory ports.
  logic          pix_we;
  logic [AW-1:0] pix_waddr, pix_raddr;
  logic [15:0]   pix_wdata, pix_rdata;
  logic          dirty_we;
  logic [TW-1:0] dirty_waddr;
  logic          dirty_wdata, dirty_rdata;

  // Draw address unit.
  draw_stat_t    draw_stat;
  logic [TW-1:0] draw_tile;
  logic [CW-1:0] draw_col;
  logic [RW-1:0] draw_row;
  logic [AW-1:0] draw_addr;
  logic          draw_go;

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign draw_go     = accept && (func == FUNC_DRAW);
  assign armed       = range_valid && (unlimited || (budget != 11'd0));
  assign sweep_dirty = (32'(sweep_cnt) < NUM_TILES);

  // Raster step of the scan position through the tile grid.
  always_comb begin
    if (scan_col == CW'(GRID_COLUMNS - 1)) begin
      scan_col_inc = '0;
      scan_row_inc = scan_row + RW'(1);
    end else begin
      scan_col_inc = scan_col + CW'(1);
      scan_row_inc = scan_row;
    end
  end

  dtf_draw_addr #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TILE_SIZE     (TILE_SIZE),
    .GRID_COLUMNS  (GRID_COLUMNS),
    .GRID_ROWS     (GRID_ROWS)
  ) u_draw_addr (
    .clk  (clk),
    .rst  (rst),
    .go   (draw_go),
    .x    (pixel_x),
    .y    (pixel_y),
    .stat (draw_stat),
    .tile (draw_tile),
    .col  (draw_col),
    .row  (draw_row),
    .addr (draw_addr)
  );

  dtf_ram #(
    .WIDTH (16),
    .DEPTH (STORE_DEPTH)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  dtf_ram #(
    .WIDTH (1),
    .DEPTH (NUM_TILES)
  ) u_dirty_ram (
    .clk   (clk),
    .we    (dirty_we),
    .waddr (dirty_waddr),
    .wdata (dirty_wdata),
    .raddr (scan_t),
    .rdata (dirty_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sweep_cnt == AW'(STORE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_DRAW:  state_next = ST_DRAW_WAIT;
            FUNC_CLEAR: state_next = ST_CLEAR;
            FUNC_TICK: begin
              if (pos != '0) begin
                state_next = ST_PIX_RD;
              end else if (armed) begin
                state_next = ST_SCAN_RD;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DRAW_WAIT: begin
        if (draw_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (dirty_rdata) begin
          state_next = ST_TILE_START;
        end else if (scan_t == range_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_TILE_START: state_next = ST_PIX_RD;
      ST_PIX_RD:     state_next = ST_PIX_OUT;
      ST_PIX_OUT:    state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Memory port control for each state.
  always_comb begin
    pix_we      = 1'b0;
    pix_waddr   = sweep_cnt;
    pix_wdata   = fill_color;
    pix_raddr   = stream_base + AW'(pos);
    dirty_we    = 1'b0;
    dirty_waddr = scan_t;
    dirty_wdata = 1'b0;
    case (state)
      ST_CLEAR: begin
        pix_we      = 1'b1;
        dirty_we    = sweep_dirty;
        dirty_waddr = TW'(sweep_cnt);
      end
      ST_DRAW_WAIT: begin
        if (draw_stat.done && draw_stat.on_screen) begin
          pix_we      = 1'b1;
          pix_waddr   = draw_addr;
          pix_wdata   = draw_color;
          dirty_we    = 1'b1;
          dirty_waddr = draw_tile;
          dirty_wdata = 1'b1;
        end
      end
      ST_SCAN_CHK: begin
        dirty_we = dirty_rdata;
      end
      default: begin
        pix_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control and flush state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt     <= '0;
      fill_color    <= '0;
      range_first   <= '0;
      range_last    <= '0;
      range_valid   <= 1'b0;
      budget        <= '0;
      unlimited     <= 1'b0;
      pos           <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_CLEAR: begin
          sweep_cnt <= sweep_cnt + AW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            case (func)
              FUNC_DRAW: begin
                draw_color <= color;
              end
              FUNC_CLEAR: begin
                fill_color    <= color;
                sweep_cnt     <= '0;
                range_valid   <= 1'b0;
                budget        <= '0;
                unlimited     <= 1'b0;
                pos           <= '0;
                result_strobe <= 1'b1;
                kind          <= KIND_CLEAR;
                window_x      <= '0;
                window_y      <= '0;
                pixel_color   <= color;
                first_of_tile <= 1'b0;
                last_of_tile  <= 1'b0;
              end
              FUNC_RENDER_COUNT: begin
                budget    <= tile_count;
                unlimited <= 1'b0;
              end
              FUNC_RENDER_ALL: begin
                unlimited <= 1'b1;
              end
              FUNC_TICK: begin
                if (pos == '0) begin
                  if (!range_valid) begin
                    budget    <= '0;
                    unlimited <= 1'b0;
                  end else if (armed) begin
                    scan_t   <= range_first;
                    scan_col <= range_first_col;
                    scan_row <= range_first_row;
                  end
                end
              end
              default: begin
                budget <= budget;
              end
            endcase
          end
        end
        ST_DRAW_WAIT: begin
          // Widen the dirty range to take in the drawn tile.
          if (draw_stat.done && draw_stat.on_screen) begin
            if (!range_valid) begin
              range_first     <= draw_tile;
              range_first_col <= draw_col;
              range_first_row <= draw_row;
              range_last      <= draw_tile;
              range_valid     <= 1'b1;
            end else if (draw_tile < range_first) begin
              range_first     <= draw_tile;
              range_first_col <= draw_col;
              range_first_row <= draw_row;
            end else if (draw_tile > range_last) begin
              range_last <= draw_tile;
            end
          end
        end
        ST_SCAN_CHK: begin
          if (dirty_rdata) begin
            // Dirty tile found: start it and move the range past it.
            if (!unlimited && (budget != 11'd0)) begin
              budget <= budget - 11'd1;
            end
            if (scan_t >= range_last) begin
              range_valid <= 1'b0;
            end else begin
              range_first     <= scan_t + TW'(1);
              range_first_col <= scan_col_inc;
              range_first_row <= scan_row_inc;
            end
          end else if (scan_t == range_last) begin
            // Range exhausted with nothing dirty: disarm the flush.
            range_valid <= 1'b0;
            budget      <= '0;
            unlimited   <= 1'b0;
          end else begin
            scan_t   <= scan_t + TW'(1);
            scan_col <= scan_col_inc;
            scan_row <= scan_row_inc;
          end
        end
        ST_TILE_START: begin
          stream_base <= AW'(32'(scan_t) * TP);
          stream_wx   <= 9'(32'(scan_col) * TILE_SIZE);
          stream_wy   <= 8'(32'(scan_row) * TILE_SIZE);
        end
        ST_PIX_OUT: begin
          result_strobe <= 1'b1;
          kind          <= KIND_PIXEL;
          window_x      <= stream_wx;
          window_y      <= stream_wy;
          pixel_color   <= pix_rdata;
          first_of_tile <= (pos == '0);
          last_of_tile  <= (pos == PW'(TP - 1));
          if (pos == PW'(TP - 1)) begin
            pos <= '0;
          end else begin
            pos <= pos + PW'(1);
          end
        end
        default: begin
          budget <= budget;
        end
      endcase
    end
  end

endmodule

### test/dirty_tile_framebuffer_flush_tb.sv
`timescale 1ns / 1ps

module dirty_tile_framebuffer_flush_tb;
  import dtf_pkg::*;

  // Geometry at the default parameter set of the block.
  localparam int unsigned SCR_W    = 320;
  localparam int unsigned SCR_H    = 240;
  localparam int unsigned TILE     = 8;
  localparam int unsigned COLS     = 40;
  localparam int unsigned TILE_PIX = TILE * TILE;
  localparam int unsigned TILES    = 1200;
  localparam int unsigned STORE    = TILES * TILE_PIX;
  localparam int unsigned WORK_TARGET = 1550;

  typedef struct packed {
    logic        kind;
    logic [8:0]  win_x;
    logic [7:0]  win_y;
    logic [15:0] colour;
    logic        first_pix;
    logic        last_pix;
  } display_write_t;

  typedef struct packed {
    logic [2:0]     f;
    logic [8:0]     x;
    logic [8:0]     y;
    logic [15:0]    c;
    logic [10:0]    n;
    bit             typed;
    bit             has;
    display_write_t res;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  func = FUNC_TICK;
  logic [8:0]  pixel_x = '0;
  logic [8:0]  pixel_y = '0;
  logic [15:0] color = '0;
  logic [10:0] tile_count = '0;
  logic        busy;
  logic        result_strobe;
  logic        kind;
  logic [8:0]  window_x;
  logic [7:0]  window_y;
  logic [15:0] pixel_color;
  logic        first_of_tile;
  logic        last_of_tile;

  // Typed expectation travelling with a directed beat.
  bit             row_typed = 1'b0;
  bit             row_has = 1'b0;
  display_write_t row_result = '0;

  // Shadow copy of the framebuffer and its flush state.
  bit [15:0]   shadow [0:STORE-1];
  bit          tile_dirty [0:TILES-1];
  int unsigned span_first = 0;
  int unsigned span_last = 0;
  bit          span_valid = 1'b0;
  int unsigned flush_left = 0;
  bit          flush_all = 1'b0;
  int unsigned stream_pos = 0;
  int unsigned stream_tile = 0;

  display_write_t pending_writes [$];
  int unsigned mismatches = 0;
  int unsigned accepted = 0;
  int unsigned work_items = 0;
  int unsigned pixels_seen = 0;
  int unsigned clears_seen = 0;
  int unsigned idle_pct = 0;
  cmd_row_t    directed_rows [$];

  dirty_tile_framebuffer_flush u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .color         (color),
    .tile_count    (tile_count),
    .result_strobe (result_strobe),
    .kind          (kind),
    .window_x      (window_x),
    .window_y      (window_y),
    .pixel_color   (pixel_color),
    .first_of_tile (first_of_tile),
    .last_of_tile  (last_of_tile)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one command to the shadow framebuffer and returns whether it
  // produces a display write.
  function automatic bit framebuffer_step(input logic [2:0] f, input logic [8:0] x,
                                          input logic [8:0] y, input logic [15:0] c,
                                          input logic [10:0] n, output display_write_t w);
    int unsigned t;
    int unsigned idx;
    bit found;
    w = '0;
    case (f)
      FUNC_DRAW: begin
        // Off-screen coordinates leave everything untouched.
        if (x < SCR_W && y < SCR_H) begin
          t = x / TILE + (y / TILE) * COLS;
          idx = t * TILE_PIX + (y % TILE) * TILE + (x % TILE);
          shadow[idx] = c;
          tile_dirty[t] = 1'b1;
          if (!span_valid) begin
            span_first = t;
            span_last = t;
            span_valid = 1'b1;
          end else if (t < span_first) begin
            span_first = t;
          end else if (t > span_last) begin
            span_last = t;
          end
        end
        return 1'b0;
      end
      FUNC_CLEAR: begin
        for (idx = 0; idx < STORE; idx++) shadow[idx] = c;
        for (t = 0; t < TILES; t++) tile_dirty[t] = 1'b0;
        span_valid = 1'b0;
        flush_left = 0;
        flush_all = 1'b0;
        stream_pos = 0;
        w.kind = KIND_CLEAR;
        w.colour = c;
        return 1'b1;
      end
      FUNC_RENDER_COUNT: begin
        flush_left = 32'(n);
        flush_all = 1'b0;
        return 1'b0;
      end
      FUNC_RENDER_ALL: begin
        flush_all = 1'b1;
        return 1'b0;
      end
      FUNC_TICK: begin
        // Between tiles: find the next dirty tile in the range, or disarm.
        if (stream_pos == 0) begin
          if (!span_valid || (!flush_all && flush_left == 0)) begin
            if (!span_valid) begin
              flush_left = 0;
              flush_all = 1'b0;
            end
            return 1'b0;
          end
          t = span_first;
          found = 1'b0;
          while (!found && t <= span_last && t < TILES) begin
            if (tile_dirty[t]) found = 1'b1;
            else t++;
          end
          if (!found) begin
            span_valid = 1'b0;
            flush_left = 0;
            flush_all = 1'b0;
            return 1'b0;
          end
          tile_dirty[t] = 1'b0;
          if (!flush_all && flush_left > 0) flush_left--;
          if (t >= span_last) span_valid = 1'b0;
          else span_first = t + 1;
          stream_tile = t;
        end
        // The store is read live, so a redraw during streaming shows up.
        idx = stream_tile * TILE_PIX + stream_pos;
        w.kind = KIND_PIXEL;
        w.win_x = 9'((stream_tile % COLS) * TILE);
        w.win_y = 8'((stream_tile / COLS) * TILE);
        w.colour = shadow[idx];
        w.first_pix = (stream_pos == 0);
        w.last_pix = (stream_pos == TILE_PIX - 1);
        stream_pos = (stream_pos + 1 >= TILE_PIX) ? 0 : stream_pos + 1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic display_write_t display_write(input logic k, input logic [8:0] wx,
                                                   input logic [7:0] wy, input logic [15:0] c,
                                                   input logic fp, input logic lp);
    display_write_t w;
    w.kind = k;
    w.win_x = wx;
    w.win_y = wy;
    w.colour = c;
    w.first_pix = fp;
    w.last_pix = lp;
    return w;
  endfunction

  function automatic cmd_row_t cmd(input logic [2:0] f, input logic [8:0] x,
                                   input logic [8:0] y, input logic [15:0] c,
                                   input logic [10:0] n, input bit typed, input bit has,
                                   input display_write_t res);
    cmd_row_t r;
    r.f = f;
    r.x = x;
    r.y = y;
    r.c = c;
    r.n = n;
    r.typed = typed;
    r.has = has;
    r.res = res;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result beats are checked against the oldest expectation; accepted
  // command beats feed the shadow model.
  always @(posedge clk) begin : monitor
    display_write_t want;
    display_write_t predicted;
    bit produces;
    if (!rst) begin
      if (result_strobe) begin
        if (pending_writes.size() == 0) begin
          $error("result beat with no write expected");
          mismatches++;
        end else begin
          want = pending_writes.pop_front();
          check_field("kind", 16'(want.kind), 16'(kind));
          check_field("window_x", 16'(want.win_x), 16'(window_x));
          check_field("window_y", 16'(want.win_y), 16'(window_y));
          check_field("pixel_color", want.colour, pixel_color);
          check_field("first_of_tile", 16'(want.first_pix), 16'(first_of_tile));
          check_field("last_of_tile", 16'(want.last_pix), 16'(last_of_tile));
          if (want.kind == KIND_CLEAR) clears_seen++;
          else pixels_seen++;
        end
      end
      if (start && !busy) begin
        produces = framebuffer_step(func, pixel_x, pixel_y, color, tile_count, predicted);
        if (row_typed) begin
          if (row_has) pending_writes.push_back(row_result);
        end else if (produces) begin
          pending_writes.push_back(predicted);
        end
        accepted++;
      end
    end
  end

  // Presents one command beat and holds it until busy reads low.
  task automatic send_cmd(input cmd_row_t r);
    start <= 1'b1;
    func <= r.f;
    pixel_x <= r.x;
    pixel_y <= r.y;
    color <= r.c;
    tile_count <= r.n;
    row_typed <= r.typed;
    row_has <= r.has;
    row_result <= r.res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic issue(input logic [2:0] f, input logic [8:0] x, input logic [8:0] y,
                       input logic [15:0] c, input logic [10:0] n);
    idle_gap();
    send_cmd(cmd(f, x, y, c, n, 1'b0, 1'b0, '0));
    if (f <= FUNC_TICK && !(f == FUNC_DRAW && (x >= SCR_W || y >= SCR_H))) work_items++;
  endtask

  task automatic draw_in_tile(input int unsigned t);
    issue(FUNC_DRAW, 9'((t % COLS) * TILE + $urandom_range(0, TILE - 1)),
          9'((t / COLS) * TILE + $urandom_range(0, TILE - 1)), 16'($urandom),
          11'($urandom));
  endtask

  // Holds the sender off until every expected write has arrived.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned ep;
    int unsigned k;
    int unsigned nd;
    int unsigned nt;
    int unsigned base;
    int unsigned pick;
    int unsigned clears_left;

    // Directed table: idle behaviour, unused codes, clears, draw extremes,
    // budget handling, a redraw and a clear during a flush.
    directed_rows.push_back(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0, '0));
    directed_rows.push_back(cmd(3'd5, 511, 511, 16'hFFFF, 11'h7FF, 1, 0, '0));
    directed_rows.push_back(cmd(3'd7, 0, 0, 16'h0000, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_CLEAR, 0, 0, 16'h1234, 0, 1, 1,
                                display_write(KIND_CLEAR, 0, 0, 16'h1234, 0, 0)));
    directed_rows.push_back(cmd(FUNC_DRAW, 0, 0, 16'hFFFF, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_DRAW, 319, 239, 16'h0001, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_DRAW, 320, 0, 16'h5555, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_DRAW, 0, 240, 16'hAAAA, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_DRAW, 511, 511, 16'hFFFF, 11'h7FF, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_RENDER_COUNT, 0, 0, 0, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_RENDER_COUNT, 0, 0, 0, 1, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 1,
                                display_write(KIND_PIXEL, 0, 0, 16'hFFFF, 1, 0)));
    directed_rows.push_back(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 1,
                                display_write(KIND_PIXEL, 0, 0, 16'h1234, 0, 0)));
    directed_rows.push_back(cmd(FUNC_RENDER_COUNT, 0, 0, 0, 11'h7FF, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_RENDER_ALL, 0, 0, 0, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, '0));
    directed_rows.push_back(cmd(FUNC_DRAW, 7, 7, 16'hA5A5, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, '0));
    directed_rows.push_back(cmd(FUNC_CLEAR, 0, 0, 16'hFFFF, 0, 1, 1,
                                display_write(KIND_CLEAR, 0, 0, 16'hFFFF, 0, 0)));
    directed_rows.push_back(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_DRAW, 319, 0, 16'h8000, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_RENDER_ALL, 0, 0, 0, 0, 1, 0, '0));
    directed_rows.push_back(cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, '0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_cmd(directed_rows[i]);
    row_typed <= 1'b0;

    // Random part: bursts of draws around a tile, a render request and a
    // run of ticks, with noise mixed in and the odd clear.
    ep = 0;
    clears_left = 2;
    while (work_items < WORK_TARGET) begin
      case (ep % 4)
        0: idle_pct = 0;
        1: idle_pct = 87;
        2: idle_pct = 0;
        default: idle_pct = 31;
      endcase
      base = $urandom_range(0, TILES - 1);
      nd = $urandom_range(1, 8);
      for (k = 0; k < nd; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) draw_in_tile((base + $urandom_range(0, 3)) % TILES);
        else if (pick < 85) draw_in_tile($urandom_range(0, TILES - 1));
        else if (pick < 93) issue(FUNC_DRAW, 9'($urandom_range(SCR_W, 511)),
                                  9'($urandom_range(0, 511)), 16'($urandom),
                                  11'($urandom));
        else if (pick < 97) issue(FUNC_DRAW, 9'($urandom_range(0, 511)),
                                  9'($urandom_range(SCR_H, 511)), 16'($urandom),
                                  11'($urandom));
        else issue(3'($urandom_range(5, 7)), 9'($urandom), 9'($urandom), 16'($urandom),
                   11'($urandom));
      end

      pick = $urandom_range(0, 99);
      if (pick < 45) issue(FUNC_RENDER_COUNT, 9'($urandom), 9'($urandom), 16'($urandom),
                           11'($urandom_range(1, 3)));
      else if (pick < 80) issue(FUNC_RENDER_ALL, 9'($urandom), 9'($urandom),
                                16'($urandom), 11'($urandom));
      else if (pick < 90) issue(FUNC_RENDER_COUNT, 9'($urandom), 9'($urandom),
                                16'($urandom), 11'd0);
      else issue(FUNC_RENDER_COUNT, 9'($urandom), 9'($urandom), 16'($urandom),
                 11'($urandom_range(0, 2047)));

      nt = TILE_PIX * $urandom_range(1, 3) + $urandom_range(0, 12);
      for (k = 0; k < nt; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) draw_in_tile((base + $urandom_range(0, 3)) % TILES);
        else if (pick < 4) issue(FUNC_RENDER_ALL, 9'($urandom), 9'($urandom),
                                 16'($urandom), 11'($urandom));
        issue(FUNC_TICK, 9'($urandom), 9'($urandom), 16'($urandom), 11'($urandom));
      end

      // A clear costs a full sweep of the store, so only a couple are sent.
      if (ep % 5 == 4 && clears_left > 0) begin
        issue(FUNC_CLEAR, 9'($urandom), 9'($urandom), 16'($urandom), 11'($urandom));
        clears_left--;
      end
      if (ep % 4 == 3 || $urandom_range(0, 9) == 0) drain_results();
      ep++;
    end

    // Let the last writes arrive and any trailing scan finish.
    drain_results();
    k = 0;
    while (busy && k < 100000) begin
      @(posedge clk);
      k++;
    end
    repeat (16) @(posedge clk);

    $display("Sent %0d command beats (%0d doing work) over %0d bursts and four idle mixes.",
             accepted, work_items, ep);
    $display("Checked %0d tile pixel beats and %0d clear-screen beats.",
             pixels_seen, clears_seen);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
